[rtl/hrhc_pkg.sv]
// Shared types, codes and string helpers for the request header classifier.
package hrhc_pkg;

  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [2:0] PH_METHOD = 3'd0;
  localparam logic [2:0] PH_TARGET = 3'd1;
  localparam logic [2:0] PH_REST   = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_LINE   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  localparam logic [2:0] VS_NAME   = 3'd0;
  localparam logic [2:0] VS_IGNORE = 3'd1;
  localparam logic [2:0] VS_LEAD   = 3'd2;
  localparam logic [2:0] VS_BODY   = 3'd3;
  localparam logic [2:0] VS_TRAIL  = 3'd4;
  localparam logic [2:0] VS_FAIL   = 3'd5;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_BAD       = 4'd1;
  localparam logic [3:0] ST_FORBIDDEN = 4'd2;
  localparam logic [3:0] ST_NOTFOUND  = 4'd3;
  localparam logic [3:0] ST_METHOD    = 4'd4;
  localparam logic [3:0] ST_LENREQ    = 4'd5;
  localparam logic [3:0] ST_TOOLARGE  = 4'd6;
  localparam logic [3:0] ST_MEDIA     = 4'd7;
  localparam logic [3:0] ST_HDRLARGE  = 4'd8;

  localparam logic [2:0] ACT_PAGE     = 3'd0;
  localparam logic [2:0] ACT_HISTREC  = 3'd2;
  localparam logic [2:0] ACT_SAVE     = 3'd4;
  localparam logic [2:0] ACT_REJECT   = 3'd5;
  localparam logic [2:0] ROUTE_HIST   = 3'd1;
  localparam logic [2:0] ROUTE_DL     = 3'd3;
  localparam logic [2:0] ROUTE_POST   = 3'd4;
  localparam logic [2:0] ROUTE_NONE   = 3'd7;

  localparam logic [1:0] K_TE  = 2'd0;
  localparam logic [1:0] K_SFS = 2'd1;
  localparam logic [1:0] K_CT  = 2'd2;
  localparam logic [1:0] K_CL  = 2'd3;

  localparam logic [0:0] REG_MAX_HDR  = 1'b0;
  localparam logic [0:0] REG_MAX_BODY = 1'b1;
  localparam logic [15:0] MAX_HDR_RST  = 16'd2048;
  localparam logic [19:0] MAX_BODY_RST = 20'd4096;
  // (4096+1)/10+1
  localparam logic [16:0] LIM_RST = 17'd410;
  // ceil(2^23/10): exact quotient for any 21-bit dividend
  localparam logic [23:0] RECIP10 = 24'd838861;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_HT = 8'h09;

  typedef struct packed {
    logic [15:0] maxh;
    logic [19:0] maxb;
    logic [16:0] lim;
  } cfg_t;

  typedef struct packed {
    logic [15:0] bc;
    logic [1:0]  tm;
    logic [2:0]  ph;
    logic [5:0]  tpos;
    logic        post;
    logic [3:0]  pc;
    logic [23:0] key;
    logic [3:0]  hnc;
    logic [2:0]  vph;
    logic [23:0] lacc;
    logic        ls;
    logic        ft;
    logic [3:0]  ferr;
    logic        vsent;
    logic        mbad;
    logic [2:0]  route;
  } st_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  status;
    logic [15:0] hlen;
    logic [19:0] clen;
    logic [23:0] rec;
  } res_t;

  function automatic st_t clear_state();
    st_t x;
    x = '0;
    x.ph = PH_METHOD;
    x.pc = 4'hf;
    x.hnc = 4'hf;
    x.route = ROUTE_NONE;
    return x;
  endfunction

  function automatic st_t set_err(input st_t x, input logic [3:0] code);
    st_t y;
    y = x;
    if (y.ferr == ST_OK) y.ferr = code;
    y.ph = PH_DONE;
    return y;
  endfunction

  function automatic logic [5:0] bump(input logic [5:0] p);
    return (p != 6'd63) ? p + 6'd1 : p;
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_HT);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  // character i of a string of length len held right-aligned in s
  function automatic logic [7:0] sch(input logic [8*33-1:0] s, input logic [5:0] len,
                                     input logic [5:0] i);
    int sh;
    sh = 8 * (int'(len) - 1 - int'(i));
    return (i < len) ? s[sh +: 8] : 8'h00;
  endfunction

  function automatic logic [5:0] name_len(input logic [1:0] k);
    case (k)
      K_TE:    return 6'd17;
      K_SFS:   return 6'd14;
      K_CT:    return 6'd12;
      default: return 6'd14;
    endcase
  endfunction

  function automatic logic [7:0] name_ch(input logic [1:0] k, input logic [5:0] i);
    case (k)
      K_TE:    return sch("transfer-encoding", 6'd17, i);
      K_SFS:   return sch("sec-fetch-site", 6'd14, i);
      K_CT:    return sch("content-type", 6'd12, i);
      default: return sch("content-length", 6'd14, i);
    endcase
  endfunction

endpackage

[rtl/hrhc_step.sv]
// Per-beat next-state and verdict logic of the header classifier.
module hrhc_step import hrhc_pkg::*; (
  input  st_t        st,
  input  cfg_t       cfg,
  input  logic [7:0] data_byte,
  input  logic       start_of_request,
  output st_t        st_nxt,
  output logic       emit,
  output res_t       res
);

  always_comb begin
    st_t n;
    logic [7:0] b;
    logic done;
    logic root, index, hit, stop;
    logic [1:0] hk;
    logic [3:0] c;
    logic [5:0] i;
    logic [23:0] lz;
    b = data_byte;
    n = start_of_request ? clear_state() : st;
    emit = 1'b0;
    res = '0;
    done = 1'b0;
    root = 1'b0;
    index = 1'b0;
    hit = 1'b0;
    stop = 1'b0;
    hk = K_TE;
    c = '0;
    i = n.tpos;
    lz = {4'd0, cfg.maxb};
    if (!n.vsent) begin
      if (n.bc != COUNT_MAX) n.bc = n.bc + 16'd1;
      if (b == CH_CR) begin
        n.tm = (n.tm == 2'd2) ? 2'd3 : 2'd1;
      end else if (b == CH_LF) begin
        done = (n.tm == 2'd3);
        n.tm = (n.tm == 2'd1) ? 2'd2 : 2'd0;
      end else begin
        n.tm = 2'd0;
      end

      if (done) begin
        n.tm = 2'd0;
        emit = 1'b1;
        n.vsent = 1'b1;
        res.action = ACT_REJECT;
        res.hlen = n.bc;
        if (n.bc > cfg.maxh) begin
          res.status = ST_HDRLARGE;
          res.hlen = '0;
        end else if (n.ferr != ST_OK) begin
          res.status = n.ferr;
        end else if (n.route <= ROUTE_DL) begin
          res.action = n.route;
          res.rec = (n.route >= ACT_HISTREC) ? n.key : 24'd0;
        end else if (n.route != ROUTE_POST) begin
          res.status = ST_BAD;
        end else if (!n.ft) begin
          res.status = ST_MEDIA;
        end else if (!n.ls) begin
          res.status = ST_LENREQ;
        end else if (n.lacc > lz) begin
          res.status = ST_TOOLARGE;
        end else if (n.lacc == 24'd0) begin
          res.status = ST_BAD;
        end else begin
          res.action = ACT_SAVE;
          res.clen = n.lacc[19:0];
        end
      end else begin
        case (n.ph)
          PH_METHOD: begin
            if (b == CH_CR) begin
              n = set_err(n, ST_BAD);
            end else if (b == CH_SP) begin
              root = n.pc[0] && (i == 6'd3);
              index = n.pc[1] && (i == 6'd4);
              n.mbad = !(root || index);
              n.post = index;
              n.pc = 4'hf;
              n.tpos = '0;
              n.key = '0;
              n.vph = '0;
              n.ph = PH_TARGET;
            end else begin
              if (i >= 6'd3 || b != sch("GET", 6'd3, i)) n.pc[0] = 1'b0;
              if (i >= 6'd4 || b != sch("POST", 6'd4, i)) n.pc[1] = 1'b0;
              n.tpos = bump(i);
            end
          end
          PH_TARGET: begin
            if (b == CH_CR || b == CH_SP) begin
              root = n.pc[0] && (i == 6'd1);
              index = n.pc[1] && (i == 6'd11);
              if (!n.vph[0]) begin
                n = set_err(n, ST_BAD);
              end else if (n.mbad) begin
                n = set_err(n, ST_METHOD);
              end else if (n.post) begin
                if (root || index) begin
                  n.route = ROUTE_POST;
                  n.ph = (b == CH_CR) ? PH_SKIP : PH_REST;
                end else begin
                  n = set_err(n, ST_NOTFOUND);
                end
              end else begin
                if (root || index) n.route = ACT_PAGE;
                else if (n.pc[2] && i == 6'd8) n.route = ROUTE_HIST;
                else if (n.pc[3] && i == 6'd17) n.route = ACT_HISTREC;
                else if (n.pc[3] && i == 6'd26) n.route = ROUTE_DL;
                else n = set_err(n, ST_NOTFOUND);
                n.ph = PH_DONE;
              end
            end else begin
              n.vph[0] = 1'b1;
              if (b == "?") n.vph[1] = 1'b1;
              if (!n.vph[1]) begin
                c = n.pc;
                if (i != 6'd0 || b != "/") c[0] = 1'b0;
                if (i >= 6'd11 || b != sch("/index.html", 6'd11, i)) c[1] = 1'b0;
                if (i >= 6'd8 || b != sch("/history", 6'd8, i)) c[2] = 1'b0;
                if (i >= 6'd26) begin
                  c[3] = 1'b0;
                end else if (i >= 6'd10 && i <= 6'd16) begin
                  // record key digits
                  if (!is_digit(b)) c[3] = 1'b0;
                  else if (c[3])
                    n.key = (n.key << 3) + (n.key << 1) + {16'd0, b - "0"};
                end else if (b != sch("/history/R0000000/download", 6'd26, i)) begin
                  c[3] = 1'b0;
                end
                n.pc = c;
                n.tpos = bump(i);
              end
            end
          end
          PH_REST: begin
            if (b == CH_CR) n.ph = PH_SKIP;
          end
          PH_SKIP: begin
            n.ph = PH_LINE;
            n.tpos = '0;
            n.hnc = 4'hf;
            n.vph = VS_NAME;
          end
          PH_LINE: begin
            if (b == CH_CR) begin
              if (n.vph == VS_NAME && i == 6'd0) begin
                n.ph = PH_DONE;
              end else begin
                if (n.vph >= VS_LEAD) begin
                  if (n.hnc == 4'b0010 &&
                      ((n.vph == VS_BODY && i == 6'd10) || n.vph == VS_TRAIL)) begin
                    n = set_err(n, ST_FORBIDDEN);
                    stop = 1'b1;
                  end else begin
                    if (n.hnc == 4'b0100) n.ft = (n.vph == VS_BODY) && (i >= 6'd33);
                    if (n.hnc == 4'b1000 && n.vph == VS_LEAD) begin
                      n = set_err(n, ST_BAD);
                      stop = 1'b1;
                    end
                  end
                end
                if (!stop) n.ph = PH_SKIP;
              end
            end else if (n.vph == VS_NAME) begin
              c = n.hnc;
              for (int k = 0; k < 4; k++) begin
                if (!hit && c[k]) begin
                  if (i < name_len(2'(k))) begin
                    if (lower(b) != name_ch(2'(k), i)) c[k] = 1'b0;
                  end else if (i == name_len(2'(k)) && b == ":") begin
                    hit = 1'b1;
                    hk = 2'(k);
                  end else begin
                    c[k] = 1'b0;
                  end
                end
              end
              if (hit) begin
                n.hnc = 4'b0001 << hk;
                n.vph = VS_LEAD;
                n.tpos = '0;
                if (hk == K_TE) begin
                  n = set_err(n, ST_BAD);
                end else if (hk == K_CL) begin
                  n.ls = 1'b1;
                  n.lacc = '0;
                end
              end else begin
                n.hnc = c;
                if (c == 4'd0) n.vph = VS_IGNORE;
                n.tpos = bump(i);
              end
            end else if (n.vph == VS_LEAD || n.vph == VS_BODY || n.vph == VS_TRAIL) begin
              if (n.vph == VS_LEAD) begin
                if (!is_blank(b)) begin
                  n.vph = VS_BODY;
                  n.tpos = '0;
                  stop = 1'b1;
                end
              end else begin
                stop = 1'b1;
              end
              // value byte
              if (stop) begin
                i = n.tpos;
                if (n.hnc == 4'b0010) begin
                  if (n.vph == VS_TRAIL) begin
                    if (!is_blank(b)) n.vph = VS_FAIL;
                  end else if (i < 6'd10) begin
                    if (lower(b) != sch("cross-site", 6'd10, i)) n.vph = VS_FAIL;
                    else n.tpos = bump(i);
                  end else begin
                    n.vph = is_blank(b) ? VS_TRAIL : VS_FAIL;
                  end
                end else if (n.hnc == 4'b0100) begin
                  if (i < 6'd33) begin
                    if (lower(b) != sch("application/x-www-form-urlencoded", 6'd33, i))
                      n.vph = VS_FAIL;
                    else n.tpos = bump(i);
                  end
                end else if (n.hnc == 4'b1000) begin
                  if (!is_digit(b)) n = set_err(n, ST_BAD);
                  else if (n.lacc > {7'd0, cfg.lim}) n = set_err(n, ST_TOOLARGE);
                  else n.lacc = (n.lacc << 3) + (n.lacc << 1) + {16'd0, b - "0"};
                end
              end
            end
          end
          default: ;
        endcase

        if (n.bc >= cfg.maxh || n.bc == COUNT_MAX) begin
          emit = 1'b1;
          n.vsent = 1'b1;
          res.action = ACT_REJECT;
          res.status = ST_HDRLARGE;
        end
      end
    end
    st_nxt = n;
  end

endmodule

[rtl/http_request_header_classifier.sv]
// Request header classifier: one byte a cycle, verdict after the blank line.
// Throughput: one byte per cycle; the input stalls only while both the result
// register and the spare register behind it hold waiting verdicts.
// A verdict is registered in the result register, or the spare if that one is held.
// Rate is set by the combinational parse step feeding the result register.
// Synchronous active-low reset restores limits to 2048 / 4096 and clears parse state.
module http_request_header_classifier import hrhc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_request,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [3:0]  out_status,
  output logic [15:0] out_header_length,
  output logic [19:0] out_content_length,
  output logic [23:0] out_record_number,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_r;
  st_t  st_r, st_nxt;
  res_t res, res_r, sk_r;
  logic emit, acc, out_valid_r, sk_valid_r, out_free;
  logic [20:0] lim_num;
  logic [44:0] lim_prod;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_BODY) ? {12'd0, cfg_r.maxb} : {16'd0, cfg_r.maxh};

  // limit on the running content-length value, worked out when the register is written
  assign lim_num  = {1'b0, pwdata[19:0]} + 21'd1;
  assign lim_prod = {24'd0, lim_num} * {21'd0, RECIP10};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.maxh <= MAX_HDR_RST;
      cfg_r.maxb <= MAX_BODY_RST;
      cfg_r.lim  <= LIM_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_MAX_HDR) begin
        cfg_r.maxh <= pwdata[15:0];
      end else begin
        cfg_r.maxb <= pwdata[19:0];
        cfg_r.lim  <= lim_prod[39:23] + 17'd1;
      end
    end
  end

  hrhc_step u_step (
    .st               (st_r),
    .cfg              (cfg_r),
    .data_byte        (in_data_byte),
    .start_of_request (in_start_of_request),
    .st_nxt           (st_nxt),
    .emit             (emit),
    .res              (res)
  );

  // spare register takes a verdict that arrives while the result register is held
  assign in_stall = sk_valid_r;
  assign acc = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= clear_state();
      out_valid_r <= 1'b0;
      sk_valid_r <= 1'b0;
    end else begin
      if (acc) st_r <= st_nxt;
      if (out_free) begin
        out_valid_r <= sk_valid_r || (acc && emit);
        sk_valid_r <= 1'b0;
      end else if (acc && emit) begin
        sk_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (sk_valid_r) res_r <= sk_r;
      else if (acc && emit) res_r <= res;
    end else if (acc && emit) begin
      sk_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = res_r.action;
  assign out_status         = res_r.status;
  assign out_header_length  = res_r.hlen;
  assign out_content_length = res_r.clen;
  assign out_record_number  = res_r.rec;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    sk_valid_r |-> out_valid_r) else $error("spare verdict with no verdict ahead of it");

  a_sent: assert property (@(posedge clk) disable iff (!rst_n)
    acc && emit |=> st_r.vsent) else $error("verdict not marked as sent");

  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(acc && emit)) else $error("verdict without a beat");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_status == ST_OK) == (out_action != ACT_REJECT)))
    else $error("status and action disagree");

endmodule

[bench/http_request_header_classifier_test.sv]
// Testbench for the request header classifier: directed requests, then random streams.
`timescale 1ns / 100ps

module http_request_header_classifier_test;
  import hrhc_pkg::*;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef enum int {
    T_TARGET,
    T_NAME,
    T_LEAD,
    T_BODY,
    T_TRAIL,
    T_FAIL,
    T_REST,
    T_SKIP,
    T_IGNORE,
    T_DONE
  } parse_step_e;

  typedef struct {
    logic [2:0]  action;
    logic [3:0]  status;
    logic [15:0] hlen;
    logic [19:0] clen;
    logic [23:0] rec;
  } verdict_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_start_of_request;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_action;
  logic [3:0]  out_status;
  logic [15:0] out_header_length;
  logic [19:0] out_content_length;
  logic [23:0] out_record_number;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  http_request_header_classifier dut (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // predictor state
  logic [15:0] lim_hdr;
  logic [19:0] lim_body;
  logic [15:0] p_count;
  logic [1:0]  p_term;
  parse_step_e p_step;
  int          p_tok;
  int          p_tok_m;
  logic        method_phase;
  logic        p_mget, p_mpost, p_post;
  logic [3:0]  p_paths;
  logic [23:0] p_key;
  logic        p_nonempty, p_query;
  logic [3:0]  p_names;
  int          p_vpos;
  logic [23:0] p_len;
  logic        p_len_seen, p_form;
  logic [3:0]  p_err;
  logic        p_sent;
  logic [2:0]  p_route;

  verdict_t    verdicts_due[$];
  int          errors;
  idle_mode_e  idle_mode;
  logic        hold_off;

  string get_s   = "GET";
  string post_s  = "POST";
  string index_s = "/index.html";
  string hist_s  = "/history";
  string key_s   = "/history/R0000000/download";
  string cross_s = "cross-site";
  string form_s  = "application/x-www-form-urlencoded";
  string hdr_names[4] = '{"transfer-encoding", "sec-fetch-site", "content-type",
                          "content-length"};

  function automatic logic [7:0] lc(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic logic blank(input logic [7:0] b);
    return b == CH_SP || b == CH_HT;
  endfunction

  task automatic parse_clear();
    p_count = '0; p_term = '0; p_step = T_TARGET; p_tok = 0;
    p_mget = 1'b1; p_mpost = 1'b1; p_post = 1'b0; p_paths = 4'hf; p_key = '0;
    p_nonempty = 1'b0; p_query = 1'b0; p_names = 4'hf; p_vpos = 0; p_len = '0;
    p_len_seen = 1'b0; p_form = 1'b0; p_err = ST_OK; p_sent = 1'b0;
    p_route = ROUTE_NONE;
    method_phase = 1'b1;
  endtask

  task automatic flag_error(input logic [3:0] code);
    if (p_err == ST_OK) p_err = code;
    p_step = T_DONE;
  endtask

  task automatic post_verdict(input logic [2:0] a, input logic [3:0] s, input logic [15:0] h,
                              input logic [19:0] c, input logic [23:0] r);
    verdict_t v;
    v.action = a; v.status = s; v.hlen = h; v.clen = c; v.rec = r;
    verdicts_due.push_back(v);
    p_sent = 1'b1;
  endtask

  task automatic close_target(input logic [7:0] b);
    logic root, idx;
    root = p_paths[0] && p_tok == 1;
    idx = p_paths[1] && p_tok == 11;
    if (!p_nonempty) begin
      flag_error(ST_BAD);
    end else if (!(p_mget && p_tok_m == 3) && !(p_mpost && p_tok_m == 4)) begin
      flag_error(ST_METHOD);
    end else if (p_post) begin
      if (root || idx) begin
        p_route = ROUTE_POST;
        p_step = (b == CH_CR) ? T_SKIP : T_REST;
      end else begin
        flag_error(ST_NOTFOUND);
      end
    end else begin
      if (root || idx) p_route = ACT_PAGE;
      else if (p_paths[2] && p_tok == 8) p_route = ROUTE_HIST;
      else if (p_paths[3] && p_tok == 17) p_route = ACT_HISTREC;
      else if (p_paths[3] && p_tok == 26) p_route = ROUTE_DL;
      else flag_error(ST_NOTFOUND);
      p_step = T_DONE;
    end
  endtask

  task automatic header_name(input logic [7:0] b);
    for (int k = 0; k < 4; k++) begin
      if (!p_names[k]) continue;
      if (p_tok < hdr_names[k].len()) begin
        if (lc(b) != hdr_names[k][p_tok]) p_names[k] = 1'b0;
      end else if (p_tok == hdr_names[k].len() && b == ":") begin
        p_names = 4'b0001 << k;
        p_step = T_LEAD;
        p_vpos = 0;
        if (k == int'(K_TE)) flag_error(ST_BAD);
        else if (k == int'(K_CL)) begin
          p_len_seen = 1'b1;
          p_len = '0;
        end
        return;
      end else begin
        p_names[k] = 1'b0;
      end
    end
    if (p_names == 4'h0) p_step = T_IGNORE;
    p_tok++;
  endtask

  task automatic value_char(input logic [7:0] b);
    logic [20:0] cap;
    if (p_names == 4'b0010) begin
      if (p_step == T_TRAIL) begin
        if (!blank(b)) p_step = T_FAIL;
      end else if (p_vpos < 10) begin
        if (lc(b) != cross_s[p_vpos]) p_step = T_FAIL;
        else p_vpos++;
      end else begin
        p_step = blank(b) ? T_TRAIL : T_FAIL;
      end
    end else if (p_names == 4'b0100) begin
      if (p_vpos < 33) begin
        if (lc(b) != form_s[p_vpos]) p_step = T_FAIL;
        else p_vpos++;
      end
    end else if (p_names == 4'b1000) begin
      cap = ({1'b0, lim_body} + 21'd1) / 21'd10 + 21'd1;
      if (b < "0" || b > "9") flag_error(ST_BAD);
      else if ({8'b0, p_len} > {11'b0, cap}) flag_error(ST_TOOLARGE);
      else p_len = p_len * 24'd10 + 24'(b - "0");
    end
  endtask

  task automatic line_close();
    if (p_step == T_NAME && p_tok == 0) begin
      p_step = T_DONE;
      return;
    end
    if (p_step inside {T_LEAD, T_BODY, T_TRAIL, T_FAIL}) begin
      if (p_names == 4'b0010 && ((p_step == T_BODY && p_vpos == 10) || p_step == T_TRAIL)) begin
        flag_error(ST_FORBIDDEN);
        return;
      end
      if (p_names == 4'b0100) p_form = (p_step == T_BODY && p_vpos >= 33);
      if (p_names == 4'b1000 && p_step == T_LEAD) begin
        flag_error(ST_BAD);
        return;
      end
    end
    p_step = T_SKIP;
  endtask

  task automatic parse_char(input logic [7:0] b);
    if (method_phase) begin
      if (b == CH_CR) begin
        method_phase = 1'b0;
        flag_error(ST_BAD);
      end else if (b == CH_SP) begin
        method_phase = 1'b0;
        p_tok_m = p_tok;
        p_post = p_mpost && p_tok == 4;
        p_paths = 4'hf; p_tok = 0; p_key = '0;
        p_step = T_TARGET;
      end else begin
        if (p_tok >= 3 || b != get_s[p_tok]) p_mget = 1'b0;
        if (p_tok >= 4 || b != post_s[p_tok]) p_mpost = 1'b0;
        if (p_tok < 63) p_tok++;
      end
      return;
    end
    case (p_step)
      T_TARGET: begin
        if (b == CH_CR || b == CH_SP) close_target(b);
        else begin
          p_nonempty = 1'b1;
          if (b == "?") p_query = 1'b1;
          if (!p_query) begin
            if (p_tok != 0 || b != "/") p_paths[0] = 1'b0;
            if (p_tok >= 11 || b != index_s[p_tok]) p_paths[1] = 1'b0;
            if (p_tok >= 8 || b != hist_s[p_tok]) p_paths[2] = 1'b0;
            if (p_tok >= 26) p_paths[3] = 1'b0;
            else if (p_tok >= 10 && p_tok <= 16) begin
              if (b < "0" || b > "9") p_paths[3] = 1'b0;
              else if (p_paths[3]) p_key = p_key * 24'd10 + 24'(b - "0");
            end else if (b != key_s[p_tok]) p_paths[3] = 1'b0;
            if (p_tok < 63) p_tok++;
          end
        end
      end
      T_REST: if (b == CH_CR) p_step = T_SKIP;
      T_SKIP: begin
        p_step = T_NAME; p_tok = 0; p_names = 4'hf; p_vpos = 0;
      end
      T_NAME, T_IGNORE, T_LEAD, T_BODY, T_TRAIL, T_FAIL: begin
        if (b == CH_CR) line_close();
        else if (p_step == T_NAME) header_name(b);
        else if (p_step == T_LEAD) begin
          if (!blank(b)) begin
            p_step = T_BODY;
            p_vpos = 0;
            value_char(b);
          end
        end else if (p_step == T_BODY || p_step == T_TRAIL) value_char(b);
      end
      default: ;
    endcase
  endtask

  task automatic predict_beat(input logic [7:0] b, input logic sor);
    logic done;
    if (sor) parse_clear();
    if (p_sent) return;
    if (p_count != 16'hffff) p_count++;
    done = 1'b0;
    if (b == CH_CR) p_term = (p_term == 2'd2) ? 2'd3 : 2'd1;
    else if (b == CH_LF) begin
      done = p_term == 2'd3;
      p_term = (p_term == 2'd1) ? 2'd2 : 2'd0;
    end else p_term = 2'd0;
    if (done) begin
      p_term = 2'd0;
      if (p_count > lim_hdr) post_verdict(ACT_REJECT, ST_HDRLARGE, 16'd0, 20'd0, 24'd0);
      else if (p_err != ST_OK) post_verdict(ACT_REJECT, p_err, p_count, 20'd0, 24'd0);
      else if (p_route <= ROUTE_DL)
        post_verdict(p_route, ST_OK, p_count, 20'd0, p_route >= ACT_HISTREC ? p_key : 24'd0);
      else if (p_route != ROUTE_POST)
        post_verdict(ACT_REJECT, ST_BAD, p_count, 20'd0, 24'd0);
      else if (!p_form) post_verdict(ACT_REJECT, ST_MEDIA, p_count, 20'd0, 24'd0);
      else if (!p_len_seen) post_verdict(ACT_REJECT, ST_LENREQ, p_count, 20'd0, 24'd0);
      else if (p_len > {4'b0, lim_body})
        post_verdict(ACT_REJECT, ST_TOOLARGE, p_count, 20'd0, 24'd0);
      else if (p_len == 24'd0) post_verdict(ACT_REJECT, ST_BAD, p_count, 20'd0, 24'd0);
      else post_verdict(ACT_SAVE, ST_OK, p_count, p_len[19:0], 24'd0);
      return;
    end
    parse_char(b);
    if (p_count >= lim_hdr || p_count == 16'hffff)
      post_verdict(ACT_REJECT, ST_HDRLARGE, 16'd0, 20'd0, 24'd0);
  endtask

  // one beat on the byte channel; valid stays high into the next beat
  task automatic send_byte(input logic [7:0] b, input logic sor);
    if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH)
      while ($urandom_range(99) < (idle_mode == IDLE_SEND ? 61 : 9)) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_start_of_request <= sor;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(b, sor);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == 0);
  endtask

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (idle_mode == IDLE_RECV) out_stall <= $urandom_range(99) < 61;
    else if (idle_mode == IDLE_BOTH) out_stall <= $urandom_range(99) < 9;
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: verdict with none expected: act %0d st %0d", $time, out_action,
                 out_status);
        errors++;
      end else begin
        v = verdicts_due.pop_front();
        if (v.action !== out_action || v.status !== out_status ||
            v.hlen !== out_header_length || v.clen !== out_content_length ||
            v.rec !== out_record_number) begin
          $display("%0t: mismatch exp act %0d st %0d hl %0d cl %0d rec %0d, got %0d %0d %0d %0d %0d",
                   $time, v.action, v.status, v.hlen, v.clen, v.rec, out_action, out_status,
                   out_header_length, out_content_length, out_record_number);
          errors++;
        end
      end
    end
  end

  // entered at a falling edge just after the last beat
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    wait_drained();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) lim_hdr = val[15:0];
    else lim_body = val[19:0];
  endtask

  function automatic string digits(input int n, input int w);
    string s;
    s = "";
    for (int i = 0; i < w; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
    return s;
  endfunction

  function automatic string rnd_case(input string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++)
      if (r[i] >= "a" && r[i] <= "z" && $urandom_range(1)) r[i] = r[i] - 8'd32;
    return r;
  endfunction

  function automatic string make_request();
    string s, paths[6];
    int sel;
    paths = '{"/", "/index.html", "/history", {"/history/R", digits(0, 7)},
              {"/history/R", digits(0, 7), "/download"}, "/histori"};
    sel = $urandom_range(9);
    if (sel < 4) begin
      s = {"GET ", paths[$urandom_range(5)]};
      if ($urandom_range(3) == 0) s = {s, "?q=1"};
      s = {s, $urandom_range(1) ? " HTTP/1.1\r\n" : "\r\n"};
    end else if (sel < 9) begin
      s = {"POST ", $urandom_range(5) == 0 ? paths[$urandom_range(5)] :
           ($urandom_range(1) ? "/" : "/index.html"), " HTTP/1.1\r\n"};
      for (int n = $urandom_range(4); n > 0; n--) begin
        case ($urandom_range(9))
          0: s = {s, rnd_case("transfer-encoding"), ": chunked\r\n"};
          1: s = {s, rnd_case("sec-fetch-site"), ": ",
                  $urandom_range(1) ? rnd_case("cross-site") : "same-origin",
                  $urandom_range(1) ? " \t" : "", "\r\n"};
          2, 3, 4: s = {s, rnd_case("content-type"), ":", $urandom_range(1) ? " " : "",
                  $urandom_range(4) ? rnd_case(form_s) : "text/plain", "\r\n"};
          5: s = {s, "Host: x\r\n"};
          default: s = {s, rnd_case("content-length"), ": ",
                  $urandom_range(9) ? digits(0, $urandom_range(1, 5)) : "1x", "\r\n"};
        endcase
      end
      if (!$urandom_range(5)) s = {s, "content-length: 12\r\n"};
    end else begin
      s = {$urandom_range(1) ? "PUT" : "GE", " /\r\n"};
    end
    s = {s, "\r\n"};
    return s;
  endfunction

  task automatic test_routes();
    send_text("GET / HTTP/1.1\r\n\r\n");
    send_text("GET /index.html?a=b HTTP/1.1\r\n\r\n");
    send_text("GET /history\r\n\r\n");
    send_text("GET /history/R0123456\r\n\r\n");
    send_text("GET /history/R9999999/download HTTP/1.1\r\n\r\n");
    send_text("GET /nope\r\n\r\n");
    send_text("DELETE / HTTP/1.1\r\n\r\n");
    send_text("GET  \r\n\r\n");
    send_text("GET\r\n\r\n");
    send_text("POST /x HTTP/1.1\r\n\r\n");
  endtask

  task automatic test_post_headers();
    send_text("POST / HTTP/1.1\r\nContent-Type: application/x-www-form-urlencoded\r\nContent-Length: 12\r\n\r\n");
    send_text("POST / HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\n");
    send_text("POST / HTTP/1.1\r\nSec-Fetch-Site: CROSS-SITE \t\r\n\r\n");
    send_text("POST / HTTP/1.1\r\ncontent-type: application/x-www-form-urlencoded\r\ncontent-length: 0\r\n\r\n");
    send_text("POST / HTTP/1.1\r\ncontent-type: application/x-www-form-urlencoded\r\ncontent-length: 99999999\r\n\r\n");
    send_text("POST / HTTP/1.1\r\ncontent-type: text/plain\r\ncontent-length: 5\r\n\r\n");
    send_text("POST / HTTP/1.1\r\ncontent-type: application/x-www-form-urlencoded\r\n\r\n");
    send_text("POST / HTTP/1.1\r\ncontent-length:\r\n\r\n");
    send_text("POST / HTTP/1.1\r\ncontent-length: 1a\r\n\r\n");
    send_text("POST / HTTP/1.1\r\ncontent-type: application/x-www-form-urlencoded\r\ncontent-length: 4097\r\n\r\n");
  endtask

  task automatic test_limits();
    write_reg(3'd0, 32'd4);
    write_reg(3'd4, 32'd1);
    send_text("GET / HTTP/1.1\r\n\r\n");
    send_text("\r\n\r\n");
    write_reg(3'd0, 32'd40);
    send_text("POST / HTTP/1.1\r\ncontent-type: application/x-www-form-urlencoded\r\ncontent-length: 1\r\n\r\n");
    write_reg(3'd0, 32'd65535);
    write_reg(3'd4, 32'h000f_ffff);
    send_text("POST / HTTP/1.1\r\ncontent-type: application/x-www-form-urlencoded\r\ncontent-length: 1048575\r\n\r\n");
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'h55, 1'b0);
    write_reg(3'd0, 32'd2048);
    write_reg(3'd4, 32'd4096);
  endtask

  task automatic test_random(input int beats);
    string s;
    int sent;
    sent = 0;
    while (sent < beats) begin
      s = make_request();
      for (int i = 0; i < s.len(); i++) begin
        if ($urandom_range(199) == 0) send_byte(8'($urandom), i == 0);
        else send_byte(s[i], i == 0);
      end
      sent += s.len();
      if ($urandom_range(7) == 0) send_text("GET /\r\n\r\nmore");
    end
  endtask

  task automatic test_back_pressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
    join_none
    test_random(100);
    wait_drained();
    wait (!hold_off);
  endtask

  initial begin
    errors = 0; hold_off = 1'b0; idle_mode = IDLE_NONE;
    in_valid = 1'b0; in_data_byte = '0; in_start_of_request = 1'b0; out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    lim_hdr = 16'd2048; lim_body = 20'd4096;
    parse_clear();
    rst_n = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    idle_mode = IDLE_NONE;
    test_routes();
    idle_mode = IDLE_SEND;
    test_post_headers();
    idle_mode = IDLE_RECV;
    test_limits();
    write_reg(3'd0, 32'd60);
    write_reg(3'd4, 32'd99);
    idle_mode = IDLE_BOTH;
    test_random(60);
    write_reg(3'd0, 32'd2048);
    write_reg(3'd4, 32'd4096);
    idle_mode = IDLE_NONE;
    test_back_pressure();
    wait_drained();
    repeat (10) @(negedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
